>>> hw/rtl/ohlb_pkg.sv
// ----------------------------------------------------------------------------
// ohlb_pkg
// Widths, constants and types for the overlay / hard-light blend pipeline.
// ----------------------------------------------------------------------------
package ohlb_pkg;

    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 3;
    localparam int IN_W    = 56;   // 7 channels, 7 bytes
    localparam int OUT_W   = 24;   // 3 channels, 3 bytes

    localparam int X_W     = 16;   // product term, 0..65025
    localparam int SA_W    = 16;   // s*(255-a)
    localparam int N_W     = 24;   // mix sum, up to 255*65025
    localparam int M_W     = 25;   // 2*N + 65025
    localparam int REC_W   = 18;
    localparam int PROD_W  = M_W + REC_W;
    localparam int QD_W    = 25;   // q*130050

    localparam logic [16:0]      FULL_SQ     = 17'd65025;
    localparam logic [16:0]      DIVISOR     = 17'd130050;
    // floor(2^34 / 130050); quotient estimate is exact or one low
    localparam logic [REC_W-1:0] RECIP       = 18'd132102;
    localparam int               RECIP_SHIFT = 34;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t             pix_t [NUM_CH];
    typedef logic [X_W-1:0]    x_t   [NUM_CH];
    typedef logic [SA_W-1:0]   sa_t  [NUM_CH];
    typedef logic [N_W-1:0]    n_t   [NUM_CH];
    typedef logic [M_W-1:0]    m_t   [NUM_CH];

endpackage

>>> hw/rtl/overlay_hard_light_blend.sv
// ----------------------------------------------------------------------------
// overlay_hard_light_blend
// Overlay / hard-light blend of one overlay pixel onto one screen pixel,
// weighted by overlay alpha, rounded half up.
// ----------------------------------------------------------------------------
//  Channel   Dir   tdata fields (low bit up)
//  s_axis    in    screen_b, screen_g, screen_r, overlay_b, overlay_g,
//                  overlay_r, overlay_alpha (8 bits each)
//  m_axis    out   out_b, out_g, out_r (8 bits each)
//  cfg       in    hard_light_mode (cfg_wdata)
//
//  One pixel per clock while m_tready does not stall the pipe.
//  Stages: product terms, alpha mix, reciprocal multiply, remainder fixup.
//  Reset (synchronous, aresetn low) clears all valid bits and the mode.
//  A stall on m_tready freezes the whole pipe; s_tready follows it.
// ----------------------------------------------------------------------------
module overlay_hard_light_blend (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // screen_b, screen_g, screen_r, overlay_b, overlay_g, overlay_r, overlay_alpha
    input  logic [ohlb_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_b, out_g, out_r
    output logic [ohlb_pkg::OUT_W-1:0]   m_tdata
);

    logic mode_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv;

    ohlb_pkg::pix_t s_in, o_in;
    ohlb_pkg::chan_t a_in;

    ohlb_pkg::x_t    x_next,  x_reg;
    ohlb_pkg::sa_t   sa_next, sa_reg;
    ohlb_pkg::chan_t a1_reg;
    ohlb_pkg::n_t    n_next,  n_reg;
    ohlb_pkg::m_t    m_next,  m_reg;
    ohlb_pkg::pix_t  q_next,  q_reg;
    ohlb_pkg::pix_t  out_next, out_reg;

    assign adv      = !v4_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v4_reg;

    always_comb begin
        for (int c = 0; c < ohlb_pkg::NUM_CH; c++) begin
            s_in[c] = s_tdata[c*ohlb_pkg::CHAN_W +: ohlb_pkg::CHAN_W];
            o_in[c] = s_tdata[(c+3)*ohlb_pkg::CHAN_W +: ohlb_pkg::CHAN_W];
            m_tdata[c*ohlb_pkg::CHAN_W +: ohlb_pkg::CHAN_W] = out_reg[c];
        end
        a_in = s_tdata[6*ohlb_pkg::CHAN_W +: ohlb_pkg::CHAN_W];
    end

    // stage 1: product term and screen weight
    always_comb begin
        logic [15:0]     so, cc;
        logic            hi;
        ohlb_pkg::chan_t sc, oc, ac;
        ac = ~a_in;
        for (int c = 0; c < ohlb_pkg::NUM_CH; c++) begin
            sc = ~s_in[c];
            oc = ~o_in[c];
            so = 16'(s_in[c] * o_in[c]);
            cc = 16'(sc * oc);
            hi = mode_reg ? o_in[c][7] : s_in[c][7];
            if (!hi) begin
                x_next[c] = 16'({so, 1'b0});
            end else begin
                x_next[c] = 16'(ohlb_pkg::FULL_SQ - {cc, 1'b0});
            end
            sa_next[c] = 16'(s_in[c] * ac);
        end
    end

    // stage 2: N = X*a + 255*s*(255-a)
    always_comb begin
        for (int c = 0; c < ohlb_pkg::NUM_CH; c++) begin
            n_next[c] = 24'(x_reg[c] * a1_reg) + {sa_reg[c], 8'd0} - {8'd0, sa_reg[c]};
        end
    end

    // stage 3: quotient estimate by reciprocal
    always_comb begin
        logic [ohlb_pkg::M_W-1:0]    mm;
        logic [ohlb_pkg::PROD_W-1:0] p;
        for (int c = 0; c < ohlb_pkg::NUM_CH; c++) begin
            mm        = {n_reg[c], 1'b0} + 25'(ohlb_pkg::FULL_SQ);
            p         = mm * ohlb_pkg::RECIP;
            m_next[c] = mm;
            q_next[c] = p[ohlb_pkg::RECIP_SHIFT +: ohlb_pkg::CHAN_W];
        end
    end

    // stage 4: remainder check, one-step correction, clamp
    always_comb begin
        logic [ohlb_pkg::QD_W-1:0] qd, rem;
        for (int c = 0; c < ohlb_pkg::NUM_CH; c++) begin
            qd  = 25'(q_reg[c] * ohlb_pkg::DIVISOR);
            rem = m_reg[c] - qd;
            if (rem >= 25'(ohlb_pkg::DIVISOR) && q_reg[c] != 8'hFF) begin
                out_next[c] = q_reg[c] + 8'd1;
            end else begin
                out_next[c] = q_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (adv) begin
                v1_reg <= s_tvalid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg   <= x_next;
            sa_reg  <= sa_next;
            a1_reg  <= a_in;
            n_reg   <= n_next;
            m_reg   <= m_next;
            q_reg   <= q_next;
            out_reg <= out_next;
        end
    end

endmodule
